### design/disc_interface_register_block_top_macros.svh
// Assertion macros shared by the disc interface register block.
`ifndef DISC_INTERFACE_REGISTER_BLOCK_TOP_MACROS_SVH
`define DISC_INTERFACE_REGISTER_BLOCK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIRB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DIRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/dirb_pkg.sv
`default_nettype none

package dirb_pkg;

	// One bus access as it sits in the input register.
	typedef struct packed {
		logic        mode;
		logic [31:0] address;
		logic [3:0]  access_size;
		logic [31:0] write_data;
	} access_t;

	// One result beat.
	typedef struct packed {
		logic        handled;
		logic [31:0] read_data;
		logic        irq_pending;
		logic        dma_start;
		logic        dma_kind;
		logic [33:0] dma_disc_offset;
		logic [31:0] dma_address;
		logic [31:0] dma_length;
	} result_t;

	localparam logic       MODE_READ  = 1'b0;
	localparam logic       MODE_WRITE = 1'b1;

	localparam logic [3:0] ACCESS_WORD = 4'd4;

	localparam logic [5:0] WINDOW_BYTES = 6'h28;

	// Register offsets inside the window.
	localparam logic [5:0] OFS_STATUS    = 6'h00;
	localparam logic [5:0] OFS_COVER     = 6'h04;
	localparam logic [5:0] OFS_CMD0      = 6'h08;
	localparam logic [5:0] OFS_CMD1      = 6'h0C;
	localparam logic [5:0] OFS_CMD2      = 6'h10;
	localparam logic [5:0] OFS_XFER_ADDR = 6'h14;
	localparam logic [5:0] OFS_XFER_LEN  = 6'h18;
	localparam logic [5:0] OFS_CONTROL   = 6'h1C;
	localparam logic [5:0] OFS_IMMEDIATE = 6'h20;
	localparam logic [5:0] OFS_CONFIG    = 6'h24;

	localparam logic [7:0] CMD_INQUIRY = 8'h12;
	localparam logic [7:0] CMD_READ    = 8'hA8;

	localparam logic [31:0] INQUIRY_BYTES = 32'h20;

	localparam logic       DMA_KIND_READ    = 1'b0;
	localparam logic       DMA_KIND_INQUIRY = 1'b1;

	// Status register fields.
	localparam logic [6:0] ST_DE_MASK  = 7'h02;
	localparam logic [6:0] ST_DE_INT   = 7'h04;
	localparam logic [6:0] ST_TC_MASK  = 7'h08;
	localparam logic [6:0] ST_TC_INT   = 7'h10;
	localparam logic [6:0] ST_BRK_MASK = 7'h20;
	localparam logic [6:0] ST_BRK_INT  = 7'h40;
	localparam logic [6:0] ST_MASKS    = ST_DE_MASK | ST_TC_MASK | ST_BRK_MASK;
	localparam logic [6:0] ST_INTS     = ST_DE_INT | ST_TC_INT | ST_BRK_INT;

	// Cover register fields.
	localparam logic [2:0] CV_MASK = 3'h2;
	localparam logic [2:0] CV_INT  = 3'h4;

	localparam int CTRL_START_BIT = 0;

endpackage

`default_nettype wire

### design/dirb_regfile.sv
`default_nettype none

module dirb_regfile #(
	parameter logic [31:0] BASE_ADDRESS = 32'hCC006000
) (
	input  wire               clk,
	input  wire               arst_n,
	input  dirb_pkg::access_t acc,
	input  wire               update,
	output dirb_pkg::result_t res
);
	import dirb_pkg::*;

	localparam logic [32:0] WindowEnd = {1'b0, BASE_ADDRESS} + {27'd0, WINDOW_BYTES};

	logic [6:0]  status_q,    status_d;
	logic [2:0]  cover_q,     cover_d;
	logic [31:0] cmd0_q,      cmd0_d;
	logic [31:0] cmd1_q,      cmd1_d;
	logic [31:0] cmd2_q,      cmd2_d;
	logic [31:0] xfer_addr_q, xfer_addr_d;
	logic [31:0] xfer_len_q,  xfer_len_d;
	logic [31:0] immediate_q, immediate_d;
	logic [31:0] config_q,    config_d;

	logic        in_window;
	logic        handled;
	logic [31:0] rel_addr;
	logic [5:0]  offset;
	logic [7:0]  opcode;
	logic        is_dma_cmd;

	assign in_window = (acc.address >= BASE_ADDRESS) && ({1'b0, acc.address} < WindowEnd);
	assign handled   = in_window && (acc.access_size == ACCESS_WORD);
	assign rel_addr  = acc.address - BASE_ADDRESS;
	assign offset    = rel_addr[5:0];
	assign opcode    = cmd0_q[31:24];
	assign is_dma_cmd = (opcode == CMD_INQUIRY) || (opcode == CMD_READ);

	always_comb begin
		status_d    = status_q;
		cover_d     = cover_q;
		cmd0_d      = cmd0_q;
		cmd1_d      = cmd1_q;
		cmd2_d      = cmd2_q;
		xfer_addr_d = xfer_addr_q;
		xfer_len_d  = xfer_len_q;
		immediate_d = immediate_q;
		config_d    = config_q;

		res = '0;
		res.handled = handled;

		if (handled && acc.mode == MODE_READ) begin
			unique case (offset)
				OFS_STATUS:    res.read_data = {25'd0, status_q};
				OFS_COVER:     res.read_data = {29'd0, cover_q};
				OFS_CMD0:      res.read_data = cmd0_q;
				OFS_CMD1:      res.read_data = cmd1_q;
				OFS_CMD2:      res.read_data = cmd2_q;
				OFS_XFER_ADDR: res.read_data = xfer_addr_q;
				OFS_XFER_LEN:  res.read_data = xfer_len_q;
				OFS_IMMEDIATE: res.read_data = immediate_q;
				OFS_CONFIG:    res.read_data = config_q;
				default:       res.read_data = '0;
			endcase
		end

		if (handled && acc.mode == MODE_WRITE) begin
			unique case (offset)
				OFS_STATUS: begin
					status_d = (status_q & ST_INTS & ~(acc.write_data[6:0] & ST_INTS)) |
						(acc.write_data[6:0] & ST_MASKS);
				end
				OFS_COVER: begin
					cover_d = (cover_q & CV_INT & ~(acc.write_data[2:0] & CV_INT)) |
						(acc.write_data[2:0] & CV_MASK);
				end
				OFS_CMD0:      cmd0_d      = acc.write_data;
				OFS_CMD1:      cmd1_d      = acc.write_data;
				OFS_CMD2:      cmd2_d      = acc.write_data;
				OFS_XFER_ADDR: xfer_addr_d = acc.write_data;
				OFS_XFER_LEN:  xfer_len_d  = acc.write_data;
				OFS_CONTROL: begin
					if (acc.write_data[CTRL_START_BIT]) begin
						// The command completes in the same access.
						if (is_dma_cmd) begin
							res.dma_start   = 1'b1;
							res.dma_address = xfer_addr_q;
							if (opcode == CMD_INQUIRY) begin
								res.dma_kind   = DMA_KIND_INQUIRY;
								res.dma_length = INQUIRY_BYTES;
							end else begin
								res.dma_kind        = DMA_KIND_READ;
								res.dma_disc_offset = {cmd1_q, 2'b00};
								res.dma_length      = xfer_len_q;
							end
							xfer_addr_d = xfer_addr_q + xfer_len_q;
							xfer_len_d  = '0;
						end else begin
							immediate_d = '0;
						end
						status_d = status_q | ST_TC_INT;
					end
				end
				OFS_IMMEDIATE: immediate_d = acc.write_data;
				OFS_CONFIG:    config_d    = acc.write_data;
				default: ;
			endcase
		end

		res.irq_pending = (|(status_d & ST_TC_INT)  && |(status_d & ST_TC_MASK))  ||
			(|(status_d & ST_DE_INT)  && |(status_d & ST_DE_MASK))  ||
			(|(status_d & ST_BRK_INT) && |(status_d & ST_BRK_MASK)) ||
			(|(cover_d & CV_INT)      && |(cover_d & CV_MASK));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= '0;
			cover_q     <= '0;
			cmd0_q      <= '0;
			cmd1_q      <= '0;
			cmd2_q      <= '0;
			xfer_addr_q <= '0;
			xfer_len_q  <= '0;
			immediate_q <= '0;
			config_q    <= '0;
		end else if (update) begin
			status_q    <= status_d;
			cover_q     <= cover_d;
			cmd0_q      <= cmd0_d;
			cmd1_q      <= cmd1_d;
			cmd2_q      <= cmd2_d;
			xfer_addr_q <= xfer_addr_d;
			xfer_len_q  <= xfer_len_d;
			immediate_q <= immediate_d;
			config_q    <= config_d;
		end
	end

endmodule

`default_nettype wire

### design/disc_interface_register_block_top.sv
// Disc interface register block: a slave for 32-bit bus accesses to a window of ten
// word registers at BASE_ADDRESS. Each input beat is one access and yields exactly one
// result beat carrying read data, the interrupt line after the access and any DMA request
// started by a control write. The block takes one access per clock cycle while m_tready
// does not hold the result beat. An access is decoded once it sits in the input register,
// and its result beat is registered in the result register when the output can advance
// (input register, then result register). The register state is updated by a single
// decode pass between those two registers. While a result beat waits, the block holds
// one more access and then drops s_tready.
`default_nettype none

`include "disc_interface_register_block_top_macros.svh"

module disc_interface_register_block_top #(
	parameter logic [31:0] BASE_ADDRESS = 32'hCC006000
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,  // address[31:0], access_size[35:32], write_data[67:36], zeros
	input  wire  [0:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [135:0] m_tdata, // handled, read_data, irq_pending, dma_start,
	                              // dma_disc_offset, dma_address, dma_length, zeros
	output logic [0:0]  m_tuser   // dma_kind
);
	import dirb_pkg::*;

	logic    valid_s1;
	access_t acc_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    advance;
	logic    update;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign update   = valid_s1 && advance;

	dirb_regfile #(
		.BASE_ADDRESS(BASE_ADDRESS)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc_s1),
		.update (update),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			acc_s1.mode        <= s_tuser[0];
			acc_s1.address     <= s_tdata[31:0];
			acc_s1.access_size <= s_tdata[35:32];
			acc_s1.write_data  <= s_tdata[67:36];
		end
		if (update) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, res_q.dma_length, res_q.dma_address, res_q.dma_disc_offset,
		res_q.dma_start, res_q.irq_pending, res_q.read_data, res_q.handled};
	assign m_tuser  = res_q.dma_kind;

	`DIRB_ASSERT_SAME(a_ready_when_empty, !valid_s1, s_tready, "input stage empty but not ready")
	`DIRB_ASSERT_NEXT(a_stage_holds, valid_s1 && !advance, valid_s1, "stalled access was lost")
	`DIRB_ASSERT_SAME(a_dma_needs_handled, m_tvalid && res_q.dma_start, res_q.handled,
		"DMA request from an unhandled access")
	`DIRB_ASSERT_SAME(a_unhandled_quiet, m_tvalid && !res_q.handled,
		res_q.read_data == 32'd0 && !res_q.dma_start, "unhandled access produced data")

endmodule

`default_nettype wire
